// ===== rtl/hsv_to_rgb_converter_core_defines.svh =====
// ----------------------------------------------------------------------------
// HSV to RGB converter assertion macros
// Shared assertion forms for the converter; they compile away under SYNTH.
// ----------------------------------------------------------------------------
`ifndef HSV_TO_RGB_CONVERTER_CORE_DEFINES_SVH
`define HSV_TO_RGB_CONVERTER_CORE_DEFINES_SVH

`ifndef SYNTH
// A condition that must hold at every clock edge out of reset.
`define HSV2RGB_ASSERT(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("hsv2rgb check failed");
// A consequence that must hold in the same cycle as its antecedent.
`define HSV2RGB_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hsv2rgb check failed");
`else
`define HSV2RGB_ASSERT(label, cond)
`define HSV2RGB_ASSERT_IMPL(label, ante, cons)
`endif

`endif

// ===== rtl/hsv2rgb_pkg.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Beat types, channel indexes and arithmetic constants shared by the modules.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

    localparam int unsigned FRAC_BITS_DEF = 12;

    localparam int unsigned HUE_W  = 9;
    localparam int unsigned CHAN_W = 8;
    localparam int unsigned OUT_W  = 13;

    localparam int unsigned HUE_FULL   = 360;
    localparam int unsigned SECTOR_DEG = 60;
    localparam int unsigned CHAN_MAX   = 255;

    // Channel weights are scaled to the common denominator 255 * 60.
    localparam int unsigned X_W = 14;
    localparam logic [X_W-1:0] X_FULL = X_W'(CHAN_MAX * SECTOR_DEG);

    // Products val * weight, and the full denominator 255 * 255 * 60.
    localparam int unsigned PROD_W = 22;
    localparam logic [PROD_W-1:0] DIV_DEN = PROD_W'(CHAN_MAX * CHAN_MAX * SECTOR_DEG);

    localparam int unsigned CH_RED   = 0;
    localparam int unsigned CH_GREEN = 1;
    localparam int unsigned CH_BLUE  = 2;

    typedef struct packed {
        logic [HUE_W-1:0]  hue;
        logic [CHAN_W-1:0] saturation;
        logic [CHAN_W-1:0] brightness;
    } hsv_pix_t;

    typedef struct packed {
        logic [OUT_W-1:0] red;
        logic [OUT_W-1:0] green;
        logic [OUT_W-1:0] blue;
    } rgb_pix_t;

    // Per-channel weights and brightness handed to the scaling lanes.
    typedef struct packed {
        logic                   valid;
        logic [CHAN_W-1:0]      val;
        logic [2:0][X_W-1:0]    x;
    } xsel_t;

endpackage

// ===== rtl/hsv2rgb_sector.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB sector stages
// Two register stages: hue sector decode, then V/p/q/t weights per channel.
// ----------------------------------------------------------------------------
`include "hsv_to_rgb_converter_core_defines.svh"

module hsv2rgb_sector (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  hsv2rgb_pkg::hsv_pix_t hsv,
    output hsv2rgb_pkg::xsel_t    xsel
);
    import hsv2rgb_pkg::*;

    typedef enum logic [2:0] {
        SEC_0 = 3'd0,
        SEC_1 = 3'd1,
        SEC_2 = 3'd2,
        SEC_3 = 3'd3,
        SEC_4 = 3'd4,
        SEC_5 = 3'd5
    } sector_t;

    // Stage A: sector and remainder within the sector.
    logic [HUE_W-1:0]  hue_c;
    logic [HUE_W-1:0]  base;
    sector_t           sector_next;
    logic [5:0]        rem_next;

    logic              va_reg;
    sector_t           sector_reg;
    logic [5:0]        rem_reg;
    logic [CHAN_W-1:0] sat_a_reg;
    logic [CHAN_W-1:0] val_a_reg;

    // Stage B: channel weights.
    logic [5:0]        inv_rem;
    logic [X_W-1:0]    sr;
    logic [X_W-1:0]    st;
    logic [X_W-1:0]    xp;
    logic [X_W-1:0]    xq;
    logic [X_W-1:0]    xt;
    logic [2:0][X_W-1:0] x_next;

    logic                vb_reg;
    logic [CHAN_W-1:0]   val_b_reg;
    logic [2:0][X_W-1:0] x_reg;

    // Hue of 360 and above acts as hue 0.
    assign hue_c = (hsv.hue >= HUE_W'(HUE_FULL)) ? '0 : hsv.hue;

    always_comb
    begin
        if (hue_c >= HUE_W'(5 * SECTOR_DEG))
        begin
            sector_next = SEC_5;
            base        = HUE_W'(5 * SECTOR_DEG);
        end
        else if (hue_c >= HUE_W'(4 * SECTOR_DEG))
        begin
            sector_next = SEC_4;
            base        = HUE_W'(4 * SECTOR_DEG);
        end
        else if (hue_c >= HUE_W'(3 * SECTOR_DEG))
        begin
            sector_next = SEC_3;
            base        = HUE_W'(3 * SECTOR_DEG);
        end
        else if (hue_c >= HUE_W'(2 * SECTOR_DEG))
        begin
            sector_next = SEC_2;
            base        = HUE_W'(2 * SECTOR_DEG);
        end
        else if (hue_c >= HUE_W'(SECTOR_DEG))
        begin
            sector_next = SEC_1;
            base        = HUE_W'(SECTOR_DEG);
        end
        else
        begin
            sector_next = SEC_0;
            base        = '0;
        end
    end

    assign rem_next = 6'(hue_c - base);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
        end
        else
        begin
            va_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        sector_reg <= sector_next;
        rem_reg    <= rem_next;
        sat_a_reg  <= hsv.saturation;
        val_a_reg  <= hsv.brightness;
    end

    // Zero saturation makes every weight equal to the full one, so grey
    // needs no path of its own.
    assign inv_rem = 6'(SECTOR_DEG) - rem_reg;
    assign sr      = X_W'(sat_a_reg) * X_W'(rem_reg);
    assign st      = X_W'(sat_a_reg) * X_W'(inv_rem);
    assign xp      = X_W'(8'(CHAN_MAX) - sat_a_reg) * X_W'(SECTOR_DEG);
    assign xq      = X_FULL - sr;
    assign xt      = X_FULL - st;

    always_comb
    begin
        unique case (sector_reg)
            SEC_0:
            begin
                x_next[CH_RED] = X_FULL; x_next[CH_GREEN] = xt; x_next[CH_BLUE] = xp;
            end
            SEC_1:
            begin
                x_next[CH_RED] = xq; x_next[CH_GREEN] = X_FULL; x_next[CH_BLUE] = xp;
            end
            SEC_2:
            begin
                x_next[CH_RED] = xp; x_next[CH_GREEN] = X_FULL; x_next[CH_BLUE] = xt;
            end
            SEC_3:
            begin
                x_next[CH_RED] = xp; x_next[CH_GREEN] = xq; x_next[CH_BLUE] = X_FULL;
            end
            SEC_4:
            begin
                x_next[CH_RED] = xt; x_next[CH_GREEN] = xp; x_next[CH_BLUE] = X_FULL;
            end
            default:
            begin
                x_next[CH_RED] = X_FULL; x_next[CH_GREEN] = xp; x_next[CH_BLUE] = xq;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vb_reg <= 1'b0;
        end
        else
        begin
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        val_b_reg <= val_a_reg;
        x_reg     <= x_next;
    end

    assign xsel.valid = vb_reg;
    assign xsel.val   = val_b_reg;
    assign xsel.x     = x_reg;

    `HSV2RGB_ASSERT_IMPL(a_sector_range, va_reg, (sector_reg <= SEC_5) && (rem_reg < 6'(SECTOR_DEG)))
    `HSV2RGB_ASSERT_IMPL(a_weight_range, vb_reg, (x_reg[CH_RED] <= X_FULL) && (x_reg[CH_GREEN] <= X_FULL) && (x_reg[CH_BLUE] <= X_FULL))

endmodule

// ===== rtl/hsv2rgb_scale.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB channel scaling
// Three lanes form floor(val * weight * 2^FRAC_BITS / (255*255*60)) over four
// register stages: product, reciprocal estimate, back-multiply, correction.
// ----------------------------------------------------------------------------
`include "hsv_to_rgb_converter_core_defines.svh"

module hsv2rgb_scale #(
    parameter int unsigned FRAC_BITS = hsv2rgb_pkg::FRAC_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  hsv2rgb_pkg::xsel_t       xsel,
    output logic                     valid,
    output logic [2:0][FRAC_BITS:0]  q
);
    import hsv2rgb_pkg::*;

    localparam int unsigned QW = FRAC_BITS + 1;
    localparam int unsigned NW = PROD_W + FRAC_BITS;
    localparam int unsigned RW = QW + PROD_W;
    // floor(2^(PROD_W+FRAC_BITS) / DIV_DEN); the estimate is never more than
    // one below the true quotient because every product is below 2^PROD_W.
    localparam logic [QW-1:0] RECIP =
        QW'((64'd1 << (PROD_W + FRAC_BITS)) / 64'(DIV_DEN));
    localparam logic [QW:0] ONE = (QW+1)'(1) << FRAC_BITS;

    logic v1_reg;
    logic v2_reg;
    logic v3_reg;
    logic v4_reg;
    logic [2:0] lane_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= xsel.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_lane
        logic [PROD_W-1:0] m_reg;
        logic [PROD_W-1:0] m2_reg;
        logic [QW-1:0]     q0_reg;
        logic [QW-1:0]     q1_reg;
        logic [RW-1:0]     qd_reg;
        logic [NW-1:0]     num_reg;
        logic [QW-1:0]     res_reg;
        logic [RW-1:0]     est_prod;
        logic [RW-1:0]     rem;
        logic [QW-1:0]     res_next;

        assign est_prod = RW'(m_reg) * RW'(RECIP);
        assign rem      = RW'(num_reg) - qd_reg;
        assign res_next = (rem >= RW'(DIV_DEN)) ? (q1_reg + QW'(1)) : q1_reg;

        always_ff @(posedge clk)
        begin
            m_reg   <= PROD_W'(xsel.val) * PROD_W'(xsel.x[i]);
            q0_reg  <= est_prod[PROD_W +: QW];
            m2_reg  <= m_reg;
            qd_reg  <= RW'(q0_reg) * RW'(DIV_DEN);
            num_reg <= {m2_reg, FRAC_BITS'(0)};
            q1_reg  <= q0_reg;
            res_reg <= res_next;
        end

        // The remainder after the estimate must stay below twice the divisor.
        assign lane_ok[i] = (RW'(num_reg) >= qd_reg) && (rem < (RW'(DIV_DEN) << 1));

        assign q[i] = res_reg;
    end

    assign valid = v4_reg;

    `HSV2RGB_ASSERT_IMPL(a_one_step_fix, v3_reg, lane_ok == 3'b111)
    `HSV2RGB_ASSERT_IMPL(a_unit_bound, v4_reg, ((QW+1)'(q[CH_RED]) <= ONE) && ((QW+1)'(q[CH_GREEN]) <= ONE) && ((QW+1)'(q[CH_BLUE]) <= ONE))

endmodule

// ===== rtl/hsv_to_rgb_converter_core.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB converter core
// Converts one HSV pixel per clock into RGB in unsigned Q1.FRAC_BITS form.
// ----------------------------------------------------------------------------
// A pixel is taken on every clock edge where start is high; busy is always
// low, so a new beat may follow in every cycle. Each result appears on rgb
// for exactly one cycle with done high, in input order. It passes through six
// register stages: sector decode, weight select, the val * weight product,
// the reciprocal estimate, the back-multiply and the one-step correction of
// the constant division. Results cannot be held off, so the receiver must
// take every beat.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_core #(
    parameter int unsigned FRAC_BITS = hsv2rgb_pkg::FRAC_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  hsv2rgb_pkg::hsv_pix_t hsv,
    output logic                  done,
    output hsv2rgb_pkg::rgb_pix_t rgb
);
    import hsv2rgb_pkg::*;

    localparam int unsigned QW = FRAC_BITS + 1;

    xsel_t                xsel;
    logic                 lane_valid;
    logic [2:0][QW-1:0]   lane_q;
    logic [2:0][QW+OUT_W-1:0] lane_ext;

    // The pipeline never stalls.
    assign busy = 1'b0;

    hsv2rgb_sector u_sector (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .hsv   (hsv),
        .xsel  (xsel)
    );

    hsv2rgb_scale #(
        .FRAC_BITS (FRAC_BITS)
    ) u_scale (
        .clk   (clk),
        .rst_n (rst_n),
        .xsel  (xsel),
        .valid (lane_valid),
        .q     (lane_q)
    );

    // Channels are kept to the output field width.
    for (genvar i = 0; i < 3; i++)
    begin : g_ext
        assign lane_ext[i] = (QW+OUT_W)'(lane_q[i]);
    end

    assign done      = lane_valid;
    assign rgb.red   = lane_ext[CH_RED][OUT_W-1:0];
    assign rgb.green = lane_ext[CH_GREEN][OUT_W-1:0];
    assign rgb.blue  = lane_ext[CH_BLUE][OUT_W-1:0];

endmodule
